/* rtl/bdg_pkg.sv */
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared types and codes for the button debounce and gesture detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_LEVEL   = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_TIME  = 2'd1;
  localparam logic [1:0] CFG_DBL_CLICK_TO   = 2'd2;
  localparam logic [1:0] CFG_HOLD_LIMIT     = 2'd3;

  // Reset values of the configuration registers
  localparam logic        RST_ACTIVE_LEVEL  = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd50;
  localparam logic [15:0] RST_DBL_CLICK_TO  = 16'd250;
  localparam logic [15:0] RST_HOLD_LIMIT    = 16'd500;

  typedef enum logic [2:0] {
    G_NONE        = 3'd0,
    G_CLICK       = 3'd1,
    G_DOUBLE      = 3'd2,
    G_LONG        = 3'd3,
    G_CLICK_LONG  = 3'd4,
    G_DOUBLE_LONG = 3'd5,
    G_RELEASE     = 3'd6
  } gesture_t;

  typedef enum logic [2:0] {
    S_IDLE             = 3'd0,
    S_PRESS_PEND       = 3'd1,
    S_PRESSED          = 3'd2,
    S_CLICK_PEND       = 3'd3,
    S_CLICK_PRESS_PEND = 3'd4,
    S_DBL_PEND         = 3'd5,
    S_DBL_PRESS_PEND   = 3'd6
  } gstate_t;

  // Debouncer report for one sample
  typedef struct packed {
    logic        stable_edge;  // debounced level changed on this sample
    logic        steady;       // sample matches the debounced level
    logic [31:0] elapsed;      // ms since the last debounced edge
  } deb_ev_t;

endpackage

`default_nettype wire

/* rtl/bdg_debounce.sv */
// ----------------------------------------------------------------------------
// bdg_debounce
// Raw level tracking and debounce window; reports edges and steady time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_debounce (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,        // process one sample this cycle
  input  wire logic            level,          // sample, 1 means pressed
  input  wire logic [31:0]     now,
  input  wire logic [15:0]     debounce_time,
  output bdg_pkg::deb_ev_t     ev
);

  logic        last_raw_level;
  logic [31:0] raw_change_time;
  logic        stable_level;
  logic [31:0] stable_change_time;

  logic        raw_change;
  logic [31:0] raw_age;
  logic        window_met;

  always_comb begin
    raw_change     = level != last_raw_level;
    raw_age        = now - raw_change_time;
    window_met     = raw_age >= {16'd0, debounce_time};
    ev.stable_edge = !raw_change && (level != stable_level) && window_met;
    ev.steady      = !raw_change && (level == stable_level);
    ev.elapsed     = now - stable_change_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_level     <= 1'b0;
      raw_change_time    <= '0;
      stable_level       <= 1'b0;
      stable_change_time <= '0;
    end else if (advance) begin
      if (raw_change) begin
        last_raw_level  <= level;
        raw_change_time <= now;
      end else if (ev.stable_edge) begin
        stable_level       <= level;
        stable_change_time <= now;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bdg_gesture_fsm.sv */
// ----------------------------------------------------------------------------
// bdg_gesture_fsm
// Seven-state gesture machine stepped by debounced edges and timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_gesture_fsm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire bdg_pkg::deb_ev_t  ev,
  input  wire logic [15:0]       dbl_click_to,
  input  wire logic [15:0]       hold_limit,
  output bdg_pkg::gesture_t      gesture
);

  bdg_pkg::gstate_t state;
  bdg_pkg::gstate_t state_next;
  logic             is_long;
  logic             click_to;

  assign is_long  = ev.elapsed >= {16'd0, hold_limit};
  assign click_to = ev.elapsed >  {16'd0, dbl_click_to};

  // Next state
  always_comb begin
    state_next = state;
    if (ev.stable_edge) begin
      unique case (state)
        bdg_pkg::S_IDLE:             state_next = bdg_pkg::S_PRESS_PEND;
        bdg_pkg::S_PRESS_PEND:       state_next = bdg_pkg::S_CLICK_PEND;
        bdg_pkg::S_PRESSED:          state_next = bdg_pkg::S_IDLE;
        bdg_pkg::S_CLICK_PEND:       state_next = bdg_pkg::S_CLICK_PRESS_PEND;
        bdg_pkg::S_CLICK_PRESS_PEND: state_next = bdg_pkg::S_DBL_PEND;
        bdg_pkg::S_DBL_PEND:         state_next = bdg_pkg::S_DBL_PRESS_PEND;
        bdg_pkg::S_DBL_PRESS_PEND:   state_next = bdg_pkg::S_CLICK_PEND;
        default:                     state_next = state;
      endcase
    end else if (ev.steady) begin
      unique case (state)
        bdg_pkg::S_CLICK_PEND:
          if (click_to) state_next = bdg_pkg::S_IDLE;
        bdg_pkg::S_PRESS_PEND, bdg_pkg::S_CLICK_PRESS_PEND,
        bdg_pkg::S_DBL_PRESS_PEND:
          if (is_long) state_next = bdg_pkg::S_PRESSED;
        bdg_pkg::S_DBL_PEND:
          if (is_long) state_next = bdg_pkg::S_IDLE;
        default: state_next = state;
      endcase
    end
  end

  // Outputs
  always_comb begin
    gesture = bdg_pkg::G_NONE;
    if (ev.stable_edge) begin
      unique case (state)
        bdg_pkg::S_PRESSED:        gesture = bdg_pkg::G_RELEASE;
        bdg_pkg::S_DBL_PRESS_PEND: gesture = bdg_pkg::G_DOUBLE;
        default:                   gesture = bdg_pkg::G_NONE;
      endcase
    end else if (ev.steady) begin
      unique case (state)
        bdg_pkg::S_CLICK_PEND:
          if (click_to) gesture = bdg_pkg::G_CLICK;
        bdg_pkg::S_PRESS_PEND:
          if (is_long) gesture = bdg_pkg::G_LONG;
        bdg_pkg::S_CLICK_PRESS_PEND:
          if (is_long) gesture = bdg_pkg::G_CLICK_LONG;
        bdg_pkg::S_DBL_PEND:
          if (is_long) gesture = bdg_pkg::G_DOUBLE;
        bdg_pkg::S_DBL_PRESS_PEND:
          if (is_long) gesture = bdg_pkg::G_DOUBLE_LONG;
        default: gesture = bdg_pkg::G_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdg_pkg::S_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/button_debounce_gesture_detector.sv */
// ----------------------------------------------------------------------------
// button_debounce_gesture_detector
// Button debouncer with click, double click and long press detection.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw button sample and a millisecond
// timestamp; each yields exactly one output transaction carrying a gesture
// code (mostly "none"). The block takes one sample per clock cycle
// sustained while the output side accepts results; a sample sits in the
// input register, then loads the result register, which offers its result,
// and the output transaction is delayed further only while the output side
// stalls. The critical path is one 32-bit wrapping subtract followed by a
// compare against a 16-bit timeout and the gesture state decode. A stalled
// result is held in the result register while the input register still
// takes one more sample, so the input side only backs up once both
// registers are full. Write configuration only while no sample is in
// flight; changes apply to the next sample processed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_gesture_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [0] raw_level, [32:1] time_ms, [39:33] zero
  // gesture stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // [2:0] gesture, [7:3] zero
);

  // Configuration registers
  logic        active_level;
  logic [15:0] debounce_time;
  logic [15:0] dbl_click_to;
  logic [15:0] hold_limit;

  // Input register
  logic        in_valid;
  logic        in_level;
  logic [31:0] in_time;

  // Result register
  logic              out_valid;
  bdg_pkg::gesture_t out_gesture;

  logic              advance;
  logic              level;
  bdg_pkg::deb_ev_t  ev;
  bdg_pkg::gesture_t gesture;

  // Move the held sample into the result register when that slot is free
  // or being drained this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Map the sample so that 1 always means pressed.
  assign level = in_level ^ !active_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level  <= bdg_pkg::RST_ACTIVE_LEVEL;
      debounce_time <= bdg_pkg::RST_DEBOUNCE_TIME;
      dbl_click_to  <= bdg_pkg::RST_DBL_CLICK_TO;
      hold_limit    <= bdg_pkg::RST_HOLD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bdg_pkg::CFG_ACTIVE_LEVEL:  active_level  <= cfg_wdata[0];
        bdg_pkg::CFG_DEBOUNCE_TIME: debounce_time <= cfg_wdata;
        bdg_pkg::CFG_DBL_CLICK_TO:  dbl_click_to  <= cfg_wdata;
        bdg_pkg::CFG_HOLD_LIMIT:    hold_limit    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture a sample whenever the input register is free or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[32:1];
    end
  end

  bdg_debounce u_debounce (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .level         (level),
    .now           (in_time),
    .debounce_time (debounce_time),
    .ev            (ev)
  );

  bdg_gesture_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ev           (ev),
    .dbl_click_to (dbl_click_to),
    .hold_limit   (hold_limit),
    .gesture      (gesture)
  );

  // Result register: load on advance, drop once the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_gesture <= gesture;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_gesture};

endmodule

`default_nettype wire

/* rtl/bdg_checker.sv */
// ----------------------------------------------------------------------------
// bdg_checker
// Port-level checks for the button debounce and gesture detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A result after an empty output slot comes from a sample accepted through the input register.
  a_rise_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching sample");

  // Only defined gesture codes, padding bits zero.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] == 5'd0) && (m_tdata[2:0] != 3'd7))
    else $error("bad gesture code");

endmodule

bind button_debounce_gesture_detector bdg_checker u_bdg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
